/* hw/rtl/hex27_pkg.sv */
// ----------------------------------------------------------------------------
// hex27_pkg
// Types, widths and arithmetic helpers shared by the 27-node hexahedron
// shape function pipeline.
// ----------------------------------------------------------------------------
package hex27_pkg;

  // fixed-point format of coordinates and results
  localparam int FRAC_BITS  = 14;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int HALF       = 1 << (FRAC_BITS - 1);

  // field and datapath widths
  localparam int CW         = 16;            // input coordinate
  localparam int TW         = CW + 1;        // clamped coordinate, holds +ONE
  localparam int VW         = 18;            // 1d basis and derivative values
  localparam int QW         = 20;            // rounded first product
  localparam int OW         = 20;            // result value
  localparam int PW         = 40;            // full products before rounding
  localparam int NW         = 5;             // node number

  localparam int NODE_COUNT = 27;
  localparam logic [NW-1:0] LAST_NODE = NW'(NODE_COUNT - 1);

  localparam int OUT_MAX    = (1 << (OW - 1)) - 1;
  localparam int OUT_MIN    = -(1 << (OW - 1));

  typedef logic signed [VW-1:0] val_t;

  // input item: one natural coordinate point
  typedef struct packed {
    logic signed [CW-1:0] coord_x;
    logic signed [CW-1:0] coord_y;
    logic signed [CW-1:0] coord_z;
  } point_t;

  // result item: one node
  typedef struct packed {
    logic [NW-1:0]        node_number;
    logic signed [OW-1:0] shape_value;
    logic signed [OW-1:0] deriv_x;
    logic signed [OW-1:0] deriv_y;
    logic signed [OW-1:0] deriv_z;
    logic                 last_node;
  } result_t;

  // three lagrange polynomials and their derivatives on one axis
  typedef struct packed {
    val_t l0;
    val_t l1;
    val_t l2;
    val_t d0;
    val_t d1;
    val_t d2;
  } axis_t;

  typedef struct packed {
    axis_t ax_x;
    axis_t ax_y;
    axis_t ax_z;
  } basis_t;

  // factors of one node, as chosen by the node sequencer
  typedef struct packed {
    logic [NW-1:0] node;
    logic          last;
    val_t          lx;
    val_t          dx;
    val_t          ly;
    val_t          dy;
    val_t          lz;
    val_t          dz;
  } factor_t;

  // round p / 2^s to nearest, ties away from zero
  function automatic logic signed [PW-1:0] rnd_shift(input logic signed [PW-1:0] p,
                                                     input int unsigned s);
    logic [PW-1:0] mag;
    logic [PW-1:0] r;
    mag = p[PW-1] ? -p : p;
    r   = (mag + (PW'(1) << (s - 1))) >> s;
    return p[PW-1] ? -$signed(r) : $signed(r);
  endfunction

  // saturate to the result range
  function automatic logic signed [OW-1:0] sat_out(input logic signed [PW-1:0] v);
    logic signed [OW-1:0] r;
    if (v > PW'(OUT_MAX)) begin
      r = OW'(OUT_MAX);
    end else if (v < PW'(OUT_MIN)) begin
      r = OW'(OUT_MIN);
    end else begin
      r = OW'(v);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/hex27_basis.sv */
// ----------------------------------------------------------------------------
// hex27_basis
// Two-stage front end: clamps each coordinate and squares it, then forms the
// three quadratic lagrange values and their derivatives per axis.
// ----------------------------------------------------------------------------
module hex27_basis import hex27_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  point_t in_point,
  output logic   out_valid,
  input  logic   out_ready,
  output basis_t out_basis
);

  // clamp a coordinate to [-1, 1]
  function automatic logic signed [TW-1:0] clamp_coord(input logic signed [CW-1:0] c);
    logic signed [TW-1:0] v;
    v = TW'(c);
    if (v > TW'(ONE)) begin
      v = TW'(ONE);
    end else if (v < -TW'(ONE)) begin
      v = -TW'(ONE);
    end
    return v;
  endfunction

  // basis values from the coordinate and its square
  function automatic axis_t make_axis(input logic signed [TW-1:0] t,
                                      input logic signed [PW-1:0] sq);
    logic signed [PW-1:0] tw;
    logic signed [PW-1:0] tone;
    axis_t a;
    tw   = PW'(t);
    tone = tw <<< FRAC_BITS;
    a.l0 = VW'(rnd_shift(sq - tone, FRAC_BITS + 1));
    a.l1 = VW'(PW'(ONE) - rnd_shift(sq, FRAC_BITS));
    a.l2 = VW'(rnd_shift(sq + tone, FRAC_BITS + 1));
    a.d0 = VW'(tw - PW'(HALF));
    a.d1 = VW'(-(tw <<< 1));
    a.d2 = VW'(tw + PW'(HALF));
    return a;
  endfunction

  logic                 v1;
  logic                 v2;
  logic                 en1;
  logic                 en2;
  logic signed [CW-1:0] coord [3];
  logic signed [TW-1:0] t1    [3];
  logic signed [PW-1:0] sq1   [3];
  axis_t                ax    [3];

  assign en2       = !v2 || out_ready;
  assign en1       = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v2;

  assign coord[0] = in_point.coord_x;
  assign coord[1] = in_point.coord_y;
  assign coord[2] = in_point.coord_z;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  // per-axis clamp and square, then basis values
  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [TW-1:0] tc;
    assign tc    = clamp_coord(coord[i]);
    assign ax[i] = make_axis(t1[i], sq1[i]);

    always_ff @(posedge clk) begin
      if (en1 && in_valid) begin
        t1[i]  <= tc;
        sq1[i] <= PW'(tc) * PW'(tc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      out_basis.ax_x <= ax[0];
      out_basis.ax_y <= ax[1];
      out_basis.ax_z <= ax[2];
    end
  end

endmodule

/* hw/rtl/hex27_node_seq.sv */
// ----------------------------------------------------------------------------
// hex27_node_seq
// Holds one point's basis values and steps through the 27 nodes, one per
// cycle unless out_ready stalls; factors come from the node position table.
// ----------------------------------------------------------------------------
module hex27_node_seq import hex27_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  basis_t  in_basis,
  output logic    out_valid,
  input  logic    out_ready,
  output factor_t out_factor
);

  // node position on an axis
  localparam logic [1:0] P_NEG = 2'd0;
  localparam logic [1:0] P_MID = 2'd1;
  localparam logic [1:0] P_POS = 2'd2;

  localparam logic [1:0] PX_TAB [NODE_COUNT] = '{
    P_NEG, P_POS, P_POS, P_NEG, P_NEG, P_POS, P_POS, P_NEG, P_MID,
    P_POS, P_MID, P_NEG, P_MID, P_POS, P_MID, P_NEG, P_NEG, P_POS,
    P_POS, P_NEG, P_MID, P_MID, P_MID, P_POS, P_MID, P_NEG, P_MID};
  localparam logic [1:0] PY_TAB [NODE_COUNT] = '{
    P_NEG, P_NEG, P_POS, P_POS, P_NEG, P_NEG, P_POS, P_POS, P_NEG,
    P_MID, P_POS, P_MID, P_NEG, P_MID, P_POS, P_MID, P_NEG, P_NEG,
    P_POS, P_POS, P_MID, P_MID, P_NEG, P_MID, P_POS, P_MID, P_MID};
  localparam logic [1:0] PZ_TAB [NODE_COUNT] = '{
    P_NEG, P_NEG, P_NEG, P_NEG, P_POS, P_POS, P_POS, P_POS, P_NEG,
    P_NEG, P_NEG, P_NEG, P_POS, P_POS, P_POS, P_POS, P_MID, P_MID,
    P_MID, P_MID, P_NEG, P_POS, P_MID, P_MID, P_MID, P_MID, P_MID};

  function automatic val_t pick_l(input axis_t a, input logic [1:0] p);
    val_t r;
    case (p)
      P_NEG:   r = a.l0;
      P_MID:   r = a.l1;
      P_POS:   r = a.l2;
      default: r = a.l1;
    endcase
    return r;
  endfunction

  function automatic val_t pick_d(input axis_t a, input logic [1:0] p);
    val_t r;
    case (p)
      P_NEG:   r = a.d0;
      P_MID:   r = a.d1;
      P_POS:   r = a.d2;
      default: r = a.d1;
    endcase
    return r;
  endfunction

  basis_t        pt;
  logic          pt_valid;
  logic [NW-1:0] cnt;
  logic          f_valid;
  logic          en;
  logic          at_last;
  logic [1:0]    px;
  logic [1:0]    py;
  logic [1:0]    pz;

  assign en        = !f_valid || out_ready;
  assign at_last   = (cnt == LAST_NODE);
  assign in_ready  = !pt_valid || (en && at_last);
  assign out_valid = f_valid;

  assign px = PX_TAB[cnt];
  assign py = PY_TAB[cnt];
  assign pz = PZ_TAB[cnt];

  // point holding register and node counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
      cnt      <= '0;
      f_valid  <= 1'b0;
    end else begin
      if (en) begin
        f_valid <= pt_valid;
        if (pt_valid) cnt <= at_last ? '0 : cnt + NW'(1);
      end
      if (in_valid && in_ready) begin
        pt_valid <= 1'b1;
      end else if (en && pt_valid && at_last) begin
        pt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) pt <= in_basis;
  end

  // factor register for the current node
  always_ff @(posedge clk) begin
    if (en && pt_valid) begin
      out_factor.node <= cnt;
      out_factor.last <= at_last;
      out_factor.lx   <= pick_l(pt.ax_x, px);
      out_factor.dx   <= pick_d(pt.ax_x, px);
      out_factor.ly   <= pick_l(pt.ax_y, py);
      out_factor.dy   <= pick_d(pt.ax_y, py);
      out_factor.lz   <= pick_l(pt.ax_z, pz);
      out_factor.dz   <= pick_d(pt.ax_z, pz);
    end
  end

endmodule

/* hw/rtl/hex27_product.sv */
// ----------------------------------------------------------------------------
// hex27_product
// Four-stage product pipeline: first multiplies, rounding, second
// multiplies, then rounding and saturation into the result register.
// ----------------------------------------------------------------------------
module hex27_product import hex27_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  factor_t in_factor,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic                 v5;
  logic                 v6;
  logic                 v7;
  logic                 v8;
  logic                 en5;
  logic                 en6;
  logic                 en7;
  logic                 en8;

  logic signed [PW-1:0] m_s;
  logic signed [PW-1:0] m_dx;
  logic signed [PW-1:0] m_dy;
  val_t                 lz5;
  val_t                 dz5;
  logic [NW-1:0]        node5;
  logic                 last5;

  logic signed [QW-1:0] q_s;
  logic signed [QW-1:0] q_dx;
  logic signed [QW-1:0] q_dy;
  val_t                 lz6;
  val_t                 dz6;
  logic [NW-1:0]        node6;
  logic                 last6;

  logic signed [PW-1:0] n_s;
  logic signed [PW-1:0] n_dx;
  logic signed [PW-1:0] n_dy;
  logic signed [PW-1:0] n_dz;
  logic [NW-1:0]        node7;
  logic                 last7;

  assign en8       = !v8 || out_ready;
  assign en7       = !v7 || en8;
  assign en6       = !v6 || en7;
  assign en5       = !v5 || en6;
  assign in_ready  = en5;
  assign out_valid = v8;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      if (en5) v5 <= in_valid;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
      if (en8) v8 <= v7;
    end
  end

  // first products: lx*ly, dx*ly, lx*dy
  always_ff @(posedge clk) begin
    if (en5 && in_valid) begin
      m_s   <= PW'(in_factor.lx) * PW'(in_factor.ly);
      m_dx  <= PW'(in_factor.dx) * PW'(in_factor.ly);
      m_dy  <= PW'(in_factor.lx) * PW'(in_factor.dy);
      lz5   <= in_factor.lz;
      dz5   <= in_factor.dz;
      node5 <= in_factor.node;
      last5 <= in_factor.last;
    end
  end

  // round first products
  always_ff @(posedge clk) begin
    if (en6 && v5) begin
      q_s   <= QW'(rnd_shift(m_s, FRAC_BITS));
      q_dx  <= QW'(rnd_shift(m_dx, FRAC_BITS));
      q_dy  <= QW'(rnd_shift(m_dy, FRAC_BITS));
      lz6   <= lz5;
      dz6   <= dz5;
      node6 <= node5;
      last6 <= last5;
    end
  end

  // second products with the z factor or its derivative
  always_ff @(posedge clk) begin
    if (en7 && v6) begin
      n_s   <= PW'(q_s) * PW'(lz6);
      n_dx  <= PW'(q_dx) * PW'(lz6);
      n_dy  <= PW'(q_dy) * PW'(lz6);
      n_dz  <= PW'(q_s) * PW'(dz6);
      node7 <= node6;
      last7 <= last6;
    end
  end

  // round, saturate and register the result
  always_ff @(posedge clk) begin
    if (en8 && v7) begin
      out_result.node_number <= node7;
      out_result.shape_value <= sat_out(rnd_shift(n_s, FRAC_BITS));
      out_result.deriv_x     <= sat_out(rnd_shift(n_dx, FRAC_BITS));
      out_result.deriv_y     <= sat_out(rnd_shift(n_dy, FRAC_BITS));
      out_result.deriv_z     <= sat_out(rnd_shift(n_dz, FRAC_BITS));
      out_result.last_node   <= last7;
    end
  end

endmodule

/* hw/rtl/hex27_lagrange_shape_functions_core.sv */
// ----------------------------------------------------------------------------
// hex27_lagrange_shape_functions_core
// Triquadratic 27-node hexahedron shape functions and their partial
// derivatives at one natural coordinate point, one node per result item.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                     item
//   point     in         point_valid / point_ready     point_t (coord_x/y/z)
//   result    out        result_valid / result_ready   result_t (one node)
//
// each point yields 27 result items, one per cycle unless result_ready
// stalls them; node items of successive points follow with no gap when the
// next point is waiting, and the sequencer takes a new point only as the
// last node of the current one is registered. the first result passes 2
// basis stages, the point hold and factor registers in the sequencer,
// and 4 product stages ending in the result register.
// synchronous reset clears all valid bits and the node counter.
// a stall on result_ready holds every occupied stage in place; the point side
// keeps taking items until the front stages fill.
//
module hex27_lagrange_shape_functions_core import hex27_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    point_valid,
  output logic    point_ready,
  input  point_t  point,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic    basis_valid;
  logic    basis_ready;
  basis_t  basis;
  logic    factor_valid;
  logic    factor_ready;
  factor_t factor;

  // clamp, square and 1d basis values
  hex27_basis u_basis (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (point_valid),
    .in_ready  (point_ready),
    .in_point  (point),
    .out_valid (basis_valid),
    .out_ready (basis_ready),
    .out_basis (basis)
  );

  // node stepping and factor selection
  hex27_node_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (basis_valid),
    .in_ready   (basis_ready),
    .in_basis   (basis),
    .out_valid  (factor_valid),
    .out_ready  (factor_ready),
    .out_factor (factor)
  );

  // triple products
  hex27_product u_prod (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (factor_valid),
    .in_ready   (factor_ready),
    .in_factor  (factor),
    .out_valid  (result_valid),
    .out_ready  (result_ready),
    .out_result (result)
  );

endmodule

/* hw/rtl/hex27_checker.sv */
// ----------------------------------------------------------------------------
// hex27_checker
// Port-level checks on the shape function core: node order, last flag,
// no result without a point in flight, and a held result while stalled.
// ----------------------------------------------------------------------------
module hex27_checker import hex27_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    point_valid,
  input logic    point_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  logic          res_acc;
  logic          pt_acc;
  logic [NW-1:0] exp_node;
  logic [3:0]    pending;

  assign res_acc = result_valid && result_ready;
  assign pt_acc  = point_valid && point_ready;

  // expected node number and points still owing results
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_node <= '0;
      pending  <= '0;
    end else begin
      if (res_acc) exp_node <= result.last_node ? '0 : exp_node + NW'(1);
      pending <= pending + 4'(pt_acc) - 4'(res_acc && result.last_node);
    end
  end

  // nodes come out in order, restarting after the last one
  a_node_order: assert property (@(posedge clk) disable iff (rst)
    res_acc |-> result.node_number == exp_node)
    else $error("node number out of order");

  // last flag marks exactly the final node
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.last_node == (result.node_number == LAST_NODE))
    else $error("last_node does not match node number");

  // no result without an accepted point
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 4'd0)
    else $error("result with no point in flight");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

bind hex27_lagrange_shape_functions_core hex27_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .point_valid  (point_valid),
  .point_ready  (point_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
